@@ sv/mlbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mlbs_pkg
// Shared constants, codes and types of the mode LED pattern and beep sequencer.
// ----------------------------------------------------------------------------
package mlbs_pkg;

	// default sizes
	localparam int TIME_BITS_DEF       = 32;
	localparam int BEEP_COUNT_BITS_DEF = 4;

	// fixed field widths
	localparam int MODE_W = 2;
	localparam int HALF_W = 16;
	localparam int LED_W  = 7;
	localparam int NIB_W  = 4;
	localparam int PER_W  = 18;        // 3*flash + pause fits in 18 bits
	localparam int REM_W  = PER_W + 1; // shifted partial remainder

	// APB register port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int REG_IW = 3;

	// register indexes
	localparam logic [REG_IW-1:0] REG_PATROL_HALF  = 3'd0;
	localparam logic [REG_IW-1:0] REG_DEPLOY_HALF  = 3'd1;
	localparam logic [REG_IW-1:0] REG_RETURN_FLASH = 3'd2;
	localparam logic [REG_IW-1:0] REG_RETURN_PAUSE = 3'd3;
	localparam logic [REG_IW-1:0] REG_BEEP_ON      = 3'd4;
	localparam logic [REG_IW-1:0] REG_BEEP_OFF     = 3'd5;
	localparam logic [REG_IW-1:0] REG_LED_ON_LEVEL = 3'd6;
	localparam logic [REG_IW-1:0] REG_BEEP_TABLE   = 3'd7;

	// register reset values
	localparam logic [HALF_W-1:0] RST_PATROL_HALF  = 16'd500;
	localparam logic [HALF_W-1:0] RST_DEPLOY_HALF  = 16'd125;
	localparam logic [HALF_W-1:0] RST_RETURN_FLASH = 16'd100;
	localparam logic [HALF_W-1:0] RST_RETURN_PAUSE = 16'd700;
	localparam logic [HALF_W-1:0] RST_BEEP_ON      = 16'd100;
	localparam logic [HALF_W-1:0] RST_BEEP_OFF     = 16'd100;
	localparam logic [LED_W-1:0]  RST_LED_ON_LEVEL = 7'd100;
	localparam logic [HALF_W-1:0] RST_BEEP_TABLE   = 16'd0;

	// item kinds (tuser)
	localparam logic ACT_ENTER = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PATROL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEPLOY = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RETURN = 2'd3;

	typedef struct packed {
		logic [HALF_W-1:0] patrol_half;
		logic [HALF_W-1:0] deploy_half;
		logic [HALF_W-1:0] return_flash;
		logic [HALF_W-1:0] return_pause;
		logic [HALF_W-1:0] beep_on;
		logic [HALF_W-1:0] beep_off;
		logic [LED_W-1:0]  led_on_level;
		logic [HALF_W-1:0] beep_table;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic enter;    // latch enter item
		logic tick;     // latch tick item, load phase and period
		logic step;     // step the beep sequencer
		logic div;      // one restoring modulo step
		logic out_load; // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_div; // steady mode or zero period: no modulo needed
	} sts_t;

endpackage

@@ sv/mlbs_regs.sv @@
// ----------------------------------------------------------------------------
// mlbs_regs
// APB register bank holding the pattern and beep timing settings.
// ----------------------------------------------------------------------------
module mlbs_regs import mlbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t              cfg_q;
	logic              wr_en;
	logic [REG_IW-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[APB_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.patrol_half  <= RST_PATROL_HALF;
			cfg_q.deploy_half  <= RST_DEPLOY_HALF;
			cfg_q.return_flash <= RST_RETURN_FLASH;
			cfg_q.return_pause <= RST_RETURN_PAUSE;
			cfg_q.beep_on      <= RST_BEEP_ON;
			cfg_q.beep_off     <= RST_BEEP_OFF;
			cfg_q.led_on_level <= RST_LED_ON_LEVEL;
			cfg_q.beep_table   <= RST_BEEP_TABLE;
		end else if (wr_en) begin
			case (idx)
				REG_PATROL_HALF:  cfg_q.patrol_half  <= pwdata[HALF_W-1:0];
				REG_DEPLOY_HALF:  cfg_q.deploy_half  <= pwdata[HALF_W-1:0];
				REG_RETURN_FLASH: cfg_q.return_flash <= pwdata[HALF_W-1:0];
				REG_RETURN_PAUSE: cfg_q.return_pause <= pwdata[HALF_W-1:0];
				REG_BEEP_ON:      cfg_q.beep_on      <= pwdata[HALF_W-1:0];
				REG_BEEP_OFF:     cfg_q.beep_off     <= pwdata[HALF_W-1:0];
				REG_LED_ON_LEVEL: cfg_q.led_on_level <= pwdata[LED_W-1:0];
				REG_BEEP_TABLE:   cfg_q.beep_table   <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PATROL_HALF:  prdata = APB_DW'(cfg_q.patrol_half);
			REG_DEPLOY_HALF:  prdata = APB_DW'(cfg_q.deploy_half);
			REG_RETURN_FLASH: prdata = APB_DW'(cfg_q.return_flash);
			REG_RETURN_PAUSE: prdata = APB_DW'(cfg_q.return_pause);
			REG_BEEP_ON:      prdata = APB_DW'(cfg_q.beep_on);
			REG_BEEP_OFF:     prdata = APB_DW'(cfg_q.beep_off);
			REG_LED_ON_LEVEL: prdata = APB_DW'(cfg_q.led_on_level);
			REG_BEEP_TABLE:   prdata = APB_DW'(cfg_q.beep_table);
			default:          prdata = '0;
		endcase
	end

endmodule

@@ sv/mlbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlbs_ctrl
// Sequencing state machine: accepts items, steps the beep logic, runs the
// bit-serial modulo and hands results to the output register.
// ----------------------------------------------------------------------------
module mlbs_ctrl import mlbs_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tuser,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam int CNT_W = $clog2(TIME_BITS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_STEP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic             acc;
	logic             out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.enter    = acc & (s_tuser == ACT_ENTER);
		cmd.tick     = acc & (s_tuser == ACT_TICK);
		cmd.step     = (state_q == ST_STEP);
		cmd.div      = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd.tick)
						state_q <= ST_STEP;
				end
				ST_STEP: begin
					cnt_q   <= CNT_W'(TIME_BITS - 1);
					state_q <= sts.skip_div ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/mlbs_dp.sv @@
// ----------------------------------------------------------------------------
// mlbs_dp
// Datapath: mode and beep state, phase, restoring modulo and result register.
// ----------------------------------------------------------------------------
module mlbs_dp import mlbs_pkg::*; #(
	parameter int TIME_BITS       = TIME_BITS_DEF,
	parameter int BEEP_COUNT_BITS = BEEP_COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [MODE_W-1:0]    new_mode,
	input  logic [TIME_BITS-1:0] now_time,
	output logic [LED_W-1:0]     led_level,
	output logic                 buzzer_on
);

	localparam logic [8:0] BMAX9 = 9'((1 << BEEP_COUNT_BITS) - 1);
	localparam logic [BEEP_COUNT_BITS-1:0] BMAX = '1;

	// sequencer state
	logic [MODE_W-1:0]          mode_q;
	logic [TIME_BITS-1:0]       start_q;
	logic [BEEP_COUNT_BITS-1:0] beeps_q;
	logic                       sounding_q;
	logic [TIME_BITS-1:0]       edge_q;

	// per-tick working registers
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] phase_q;
	logic [PER_W-1:0]     period_q;
	logic [PER_W-1:0]     rem_q;
	logic [LED_W-1:0]     led_q;
	logic                 buzz_q;

	logic [NIB_W-1:0]           nib;
	logic [BEEP_COUNT_BITS-1:0] count;
	logic [PER_W-1:0]           period_d;
	logic [REM_W-1:0]           trial;
	logic [TIME_BITS-1:0]       edge_diff;
	logic                       edge_due;
	logic [PER_W-1:0]           p;
	logic [PER_W-1:0]           f1;
	logic [PER_W-1:0]           f2;
	logic [PER_W-1:0]           f3;
	logic                       led_on;

	// beep count for the mode being entered, saturated to the counter range
	always_comb begin
		case (new_mode)
			MODE_STOP:   nib = cfg.beep_table[3:0];
			MODE_PATROL: nib = cfg.beep_table[7:4];
			MODE_DEPLOY: nib = cfg.beep_table[11:8];
			MODE_RETURN: nib = cfg.beep_table[15:12];
			default:     nib = '0;
		endcase
		count = (9'(nib) > BMAX9) ? BMAX : BEEP_COUNT_BITS'(nib);
	end

	// full pattern period of the current mode
	always_comb begin
		case (mode_q)
			MODE_PATROL: period_d = PER_W'({cfg.patrol_half, 1'b0});
			MODE_DEPLOY: period_d = PER_W'({cfg.deploy_half, 1'b0});
			MODE_RETURN: period_d = PER_W'(cfg.return_flash)
			                      + PER_W'({cfg.return_flash, 1'b0})
			                      + PER_W'(cfg.return_pause);
			default:     period_d = '0;
		endcase
	end

	assign sts.skip_div = (mode_q == MODE_STOP) || (period_q == '0);

	// one restoring step: shift in the next phase bit, subtract if it fits
	assign trial = {rem_q, phase_q[TIME_BITS-1]};

	// signed wrap compare: edge reached when now - edge is not negative
	assign edge_diff = now_q - edge_q;
	assign edge_due  = (beeps_q != '0) && !edge_diff[TIME_BITS-1];

	always_comb begin
		p  = rem_q;
		f1 = PER_W'(cfg.return_flash);
		f2 = PER_W'({cfg.return_flash, 1'b0});
		f3 = f1 + f2;
		case (mode_q)
			MODE_STOP:   led_on = 1'b1;
			MODE_PATROL: led_on = (period_q != '0) && (p < PER_W'(cfg.patrol_half));
			MODE_DEPLOY: led_on = (period_q != '0) && (p < PER_W'(cfg.deploy_half));
			MODE_RETURN: led_on = (period_q != '0) && ((p < f1) || ((p >= f2) && (p < f3)));
			default:     led_on = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_STOP;
			start_q    <= '0;
			beeps_q    <= '0;
			sounding_q <= 1'b0;
			edge_q     <= '0;
		end else if (cmd.enter) begin
			mode_q     <= new_mode;
			start_q    <= now_time;
			beeps_q    <= count;
			sounding_q <= (count != '0);
			edge_q     <= now_time + TIME_BITS'(cfg.beep_on);
		end else if (cmd.step && edge_due) begin
			if (sounding_q) begin
				sounding_q <= 1'b0;
				beeps_q    <= beeps_q - 1'b1;
				edge_q     <= now_q + TIME_BITS'(cfg.beep_off);
			end else begin
				sounding_q <= 1'b1;
				edge_q     <= now_q + TIME_BITS'(cfg.beep_on);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			now_q    <= now_time;
			phase_q  <= now_time - start_q;
			period_q <= period_d;
			rem_q    <= '0;
		end else if (cmd.div) begin
			phase_q <= phase_q << 1;
			if (trial >= REM_W'(period_q))
				rem_q <= PER_W'(trial - REM_W'(period_q));
			else
				rem_q <= PER_W'(trial);
		end
		if (cmd.out_load) begin
			led_q  <= led_on ? cfg.led_on_level : '0;
			buzz_q <= (beeps_q != '0) && sounding_q;
		end
	end

	assign led_level = led_q;
	assign buzzer_on = buzz_q;

endmodule

@@ sv/mode_led_pattern_beep_sequencer.sv @@
// ----------------------------------------------------------------------------
// mode_led_pattern_beep_sequencer
// Mode-dependent LED blink pattern and beep-code sequencer, top level.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: s_tuser is the item kind (0 enter mode, 1 tick),
//   s_tdata carries new_mode and now_time (ms, wrapping). An enter item
//   sets mode, start time and beep count and gives no result; it is taken
//   in the idle state, and the block stays ready.
//   A tick item gives one result on m_*: LED duty level and buzzer bit.
//   A tick steps the beep sequencer, runs the bit-serial restoring modulo
//   of the phase by the pattern period, one phase bit per cycle, then loads
//   the output register; steady mode or a zero period skips the modulo.
//   One tick is in flight at a time; s_tready is low while it is worked on,
//   so the next item is taken only once the tick's result is loaded. The
//   finished result sits in an output register, so a new item is accepted
//   while m_tvalid waits on m_tready. If the receiver stalls, the next tick
//   waits at its last step until the register frees. Reset: stop mode,
//   start time, beep state cleared; registers take their default timings.
//   Registers are to be written over APB by the user only while the block
//   idles; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mode_led_pattern_beep_sequencer import mlbs_pkg::*; #(
	parameter int TIME_BITS       = TIME_BITS_DEF,
	parameter int BEEP_COUNT_BITS = BEEP_COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input item stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [((MODE_W + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata, // new_mode, now_time
	input  logic              s_tuser,   // action
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // led_level, buzzer_on
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t                 cfg;
	cmd_t                 cmd;
	sts_t                 sts;
	logic [MODE_W-1:0]    new_mode;
	logic [TIME_BITS-1:0] now_time;
	logic [LED_W-1:0]     led_level;
	logic                 buzzer_on;

	// unpack the input item
	assign new_mode = s_tdata[MODE_W-1:0];
	assign now_time = s_tdata[MODE_W +: TIME_BITS];

	// pack the result item
	assign m_tdata = {buzzer_on, led_level};

	mlbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// controller: item handshake, modulo bit count, result register valid
	mlbs_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: sequencer state, phase modulo, pattern decode
	mlbs_dp #(
		.TIME_BITS       (TIME_BITS),
		.BEEP_COUNT_BITS (BEEP_COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.new_mode  (new_mode),
		.now_time  (now_time),
		.led_level (led_level),
		.buzzer_on (buzzer_on)
	);

endmodule

@@ sv/mlbs_checker.sv @@
// ----------------------------------------------------------------------------
// mlbs_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mlbs_checker import mlbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic tick_acc;
	logic enter_acc;

	assign tick_acc  = s_tvalid && s_tready && (s_tuser == ACT_TICK);
	assign enter_acc = s_tvalid && s_tready && (s_tuser == ACT_ENTER);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted tick closes the input behind it
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> !s_tready ##1 !s_tready)
		else $error("input reopened too early after tick");

	// an enter item is absorbed at once
	a_enter_ready: assert property (@(posedge clk) disable iff (!arst_n)
		enter_acc |=> s_tready)
		else $error("enter item stalled the input");

	// a new result only follows tick processing
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without tick processing");

endmodule

bind mode_led_pattern_beep_sequencer mlbs_checker u_mlbs_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mode LED pattern and beep sequencer: enter and
// tick items go in on the s_* stream, every tick result on m_* is compared
// field by field with a cycle-free model of mode, pattern and beep state.
// ----------------------------------------------------------------------------
module testbench;
	import mlbs_pkg::*;

	localparam int S_DW       = ((MODE_W + 32 + 7) / 8) * 8;
	localparam int QUIET_MAX  = 4000; // cycles without any handshake or APB access
	localparam int SETTLE     = 50;   // margin that outlasts one tick in flight
	localparam int STALL_AT   = 400;  // result count that triggers the long hold-off
	localparam int STALL_LEN  = 500;
	localparam int RUN_ITEMS  = 205;  // items per random phase, at least
	localparam int N_PHASES   = 8;

	typedef struct packed {
		logic              action;
		logic [MODE_W-1:0] mode;
		logic [31:0]       now;
	} item_t;

	typedef struct packed {
		logic [LED_W-1:0] led;
		logic             buzz;
	} led_buzz_t;

	// DUT signals; the ones the bench drives are known from time zero
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [S_DW-1:0]   s_tdata  = '0;  // new_mode [1:0], now_time [33:2]
	logic              s_tuser  = 1'b0; // action
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;         // led_level [6:0], buzzer_on [7]
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	mode_led_pattern_beep_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	item_t     pending_q[$];   // items waiting for the driver
	led_buzz_t led_buzz_q[$];  // predicted tick results, oldest first
	item_t     cur_item;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        fails         = 0;
	int        items_in      = 0;
	int        results_seen  = 0;
	int        cfg_writes    = 0;
	int        stall_left    = 0;
	bit        stall_done    = 1'b0;
	int        quiet         = 0;

	// register mirror, reset values
	cfg_t cfg_m = '{
		patrol_half:  RST_PATROL_HALF,
		deploy_half:  RST_DEPLOY_HALF,
		return_flash: RST_RETURN_FLASH,
		return_pause: RST_RETURN_PAUSE,
		beep_on:      RST_BEEP_ON,
		beep_off:     RST_BEEP_OFF,
		led_on_level: RST_LED_ON_LEVEL,
		beep_table:   RST_BEEP_TABLE
	};

	// sequencer state mirror
	logic [MODE_W-1:0] sq_mode  = MODE_STOP;
	logic [31:0]       sq_start = '0;
	logic [NIB_W-1:0]  sq_beeps = '0;
	logic              sq_sound = 1'b0;
	logic [31:0]       sq_edge  = '0;

	// ------------------------------------------------------------------
	// pattern and beep prediction
	// ------------------------------------------------------------------
	function automatic logic pattern_lit(input logic [MODE_W-1:0] mode,
			input logic [31:0] phase);
		longint unsigned half, f, per, p;
		case (mode)
			MODE_STOP: begin
				return 1'b1;
			end
			MODE_PATROL, MODE_DEPLOY: begin
				half = (mode == MODE_PATROL) ? cfg_m.patrol_half : cfg_m.deploy_half;
				per  = 2 * half;
				if (per == 0)
					return 1'b0;
				return (phase % per) < half;
			end
			default: begin
				// flash, gap, flash, then the long pause
				f   = cfg_m.return_flash;
				per = 3 * f + cfg_m.return_pause;
				if (per == 0)
					return 1'b0;
				p = phase % per;
				if (p < f)
					return 1'b1;
				if (p < 2 * f)
					return 1'b0;
				return p < 3 * f;
			end
		endcase
	endfunction

	task automatic advance_sequencer(input item_t it);
		led_buzz_t  r;
		logic [31:0] lag;
		logic        lit;
		if (it.action == ACT_ENTER) begin
			sq_mode  = it.mode;
			sq_start = it.now;
			sq_beeps = cfg_m.beep_table[it.mode * NIB_W +: NIB_W];
			sq_sound = (sq_beeps != 0);
			sq_edge  = it.now + cfg_m.beep_on;
		end else begin
			lit = pattern_lit(sq_mode, it.now - sq_start);
			// signed wrap compare: edge reached when now - edge is non-negative
			lag = it.now - sq_edge;
			if (sq_beeps != 0 && !lag[31]) begin
				if (sq_sound) begin
					sq_sound = 1'b0;
					sq_beeps = sq_beeps - 1'b1;
					sq_edge  = it.now + cfg_m.beep_off;
				end else begin
					sq_sound = 1'b1;
					sq_edge  = it.now + cfg_m.beep_on;
				end
			end
			r.led  = lit ? cfg_m.led_on_level : '0;
			r.buzz = (sq_beeps != 0) && sq_sound;
			led_buzz_q.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// driver: one item on offer at a time, prediction at acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			advance_sequencer(cur_item);
			items_in++;
		end
		if (!s_tvalid || s_tready) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_item = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(S_DW - MODE_W - 32){1'b0}}, cur_item.now, cur_item.mode};
				s_tuser  <= cur_item.action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: compare results, random back-pressure, one long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin : mon
		led_buzz_t e;
		if (m_tvalid && m_tready) begin
			if (led_buzz_q.size() == 0) begin
				$error("result with none predicted: m_tdata=%h", m_tdata);
				fails++;
			end else begin
				e = led_buzz_q.pop_front();
				if (m_tdata[LED_W-1:0] !== e.led) begin
					$error("led_level: expected %0d, got %0d", e.led, m_tdata[LED_W-1:0]);
					fails++;
				end
				if (m_tdata[7] !== e.buzz) begin
					$error("buzzer_on: expected %0d, got %0d", e.buzz, m_tdata[7]);
					fails++;
				end
			end
			results_seen++;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (results_seen >= STALL_AT && !stall_done) begin
			// long hold-off: the block fills its output register and stalls input
			stall_done = 1'b1;
			stall_left = STALL_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with nothing moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("timeout: %0d quiet cycles, %0d results waiting", quiet,
				led_buzz_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_item(input logic action, input logic [MODE_W-1:0] mode,
			input logic [31:0] now);
		item_t it;
		it.action = action;
		it.mode   = mode;
		it.now    = now;
		pending_q.push_back(it);
	endtask

	// APB write: setup, access, register taken at the access edge
	task automatic reg_write(input logic [REG_IW-1:0] idx, input logic [15:0] val);
		logic [31:0] junk;
		junk = $urandom;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk[31:16], val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PATROL_HALF:  cfg_m.patrol_half  = val;
			REG_DEPLOY_HALF:  cfg_m.deploy_half  = val;
			REG_RETURN_FLASH: cfg_m.return_flash = val;
			REG_RETURN_PAUSE: cfg_m.return_pause = val;
			REG_BEEP_ON:      cfg_m.beep_on      = val;
			REG_BEEP_OFF:     cfg_m.beep_off     = val;
			REG_LED_ON_LEVEL: cfg_m.led_on_level = val[LED_W-1:0];
			default:          cfg_m.beep_table   = val;
		endcase
		cfg_writes++;
	endtask

	// all items in, all results out, then margin for a tick still in flight
	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || led_buzz_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_timing();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 16'($urandom_range(1, 1000));
		if (r < 65) return 16'd0;
		if (r < 75) return 16'hFFFF;
		if (r < 80) return 16'd1;
		return 16'($urandom);
	endfunction

	// mostly enter + ascending ticks, some loose noise items
	task automatic gen_run(input int target);
		int          n, k, ticks, scale, r;
		logic [31:0] t;
		logic [15:0] v;
		n = 0;
		while (n < target) begin
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(4))
					0: v = cfg_m.patrol_half;
					1: v = cfg_m.deploy_half;
					2: v = cfg_m.return_flash + cfg_m.return_pause;
					3: v = cfg_m.beep_on;
					default: v = cfg_m.beep_off;
				endcase
				scale = v / 3 + 1;
				if ($urandom_range(99) < 70)
					t = $urandom;
				else
					t = 32'hFFFF_FFFF - $urandom_range(0, 4 * scale);
				push_item(ACT_ENTER, 2'($urandom_range(3)), t);
				ticks = $urandom_range(3, 25);
				for (k = 0; k < ticks; k++) begin
					r = $urandom_range(99);
					if (r < 70)
						t = t + $urandom_range(0, scale);
					else if (r < 93)
						t = t + $urandom_range(0, 4 * scale);
					else
						t = $urandom;
					// new_mode rides along on ticks and must be ignored
					push_item(ACT_TICK, 2'($urandom_range(3)), t);
				end
				n += ticks + 1;
			end else begin
				push_item(1'($urandom_range(1)), 2'($urandom_range(3)), $urandom);
				n++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int p;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 50;

		// reset settings: stop mode after reset, wrap of the patrol phase
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0000);
		push_item(ACT_TICK,  MODE_RETURN, 32'hFFFF_FFFF);
		push_item(ACT_ENTER, MODE_PATROL, 32'hFFFF_FF00);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_00F0);
		push_item(ACT_TICK,  MODE_DEPLOY, 32'h0000_0100);
		drain();

		// fifteen beeps across the time wrap, LED level above 100
		reg_write(REG_BEEP_TABLE,   16'hF210);
		reg_write(REG_LED_ON_LEVEL, 16'd127);
		reg_write(REG_BEEP_ON,      16'd1);
		reg_write(REG_BEEP_OFF,     16'd1);
		push_item(ACT_ENTER, MODE_RETURN, 32'hFFFF_FFFE);
		push_item(ACT_TICK,  MODE_STOP,   32'hFFFF_FFFF);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0000);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0001);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0002);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0003);
		push_item(ACT_ENTER, MODE_DEPLOY, 32'h0000_0005);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0005);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0082);
		push_item(ACT_TICK,  MODE_STOP,   32'h0000_0006);
		drain();

		// zero periods turn every blinking pattern off; level 0 on stop
		reg_write(REG_PATROL_HALF,  16'd0);
		reg_write(REG_DEPLOY_HALF,  16'd0);
		reg_write(REG_RETURN_FLASH, 16'd0);
		reg_write(REG_RETURN_PAUSE, 16'd0);
		reg_write(REG_LED_ON_LEVEL, 16'd0);
		push_item(ACT_ENTER, MODE_PATROL, 32'h8000_0000);
		push_item(ACT_TICK,  MODE_STOP,   32'h8000_0001);
		push_item(ACT_ENTER, MODE_DEPLOY, 32'h7FFF_FFFF);
		push_item(ACT_TICK,  MODE_STOP,   32'h8000_0000);
		push_item(ACT_ENTER, MODE_RETURN, 32'h0000_0000);
		push_item(ACT_TICK,  MODE_RETURN, 32'hAAAA_AAAA);
		push_item(ACT_ENTER, MODE_STOP,   32'h5555_5555);
		push_item(ACT_TICK,  MODE_RETURN, 32'h5555_5556);
		drain();

		for (p = 0; p < N_PHASES; p++) begin
			// back-pressure: receiver idles most, then sender, then neither
			if (p < 3) begin
				send_idle_pct = 25;
				recv_idle_pct = 50;
			end else if (p < 6) begin
				send_idle_pct = 50;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 1) begin
				// every timing and table register at its top value, LED level 100
				reg_write(REG_PATROL_HALF,  16'hFFFF);
				reg_write(REG_DEPLOY_HALF,  16'hFFFF);
				reg_write(REG_RETURN_FLASH, 16'hFFFF);
				reg_write(REG_RETURN_PAUSE, 16'hFFFF);
				reg_write(REG_BEEP_ON,      16'hFFFF);
				reg_write(REG_BEEP_OFF,     16'hFFFF);
				reg_write(REG_LED_ON_LEVEL, 16'd100);
				reg_write(REG_BEEP_TABLE,   16'hFFFF);
			end else if (p == 4) begin
				// shortest timings, no pause in return mode
				reg_write(REG_PATROL_HALF,  16'd1);
				reg_write(REG_DEPLOY_HALF,  16'd1);
				reg_write(REG_RETURN_FLASH, 16'd1);
				reg_write(REG_RETURN_PAUSE, 16'd0);
				reg_write(REG_BEEP_ON,      16'd1);
				reg_write(REG_BEEP_OFF,     16'd1);
				reg_write(REG_LED_ON_LEVEL, 16'd1);
				reg_write(REG_BEEP_TABLE,   16'h1111);
			end else begin
				reg_write(REG_PATROL_HALF,  rand_timing());
				reg_write(REG_DEPLOY_HALF,  rand_timing());
				reg_write(REG_RETURN_FLASH, rand_timing());
				reg_write(REG_RETURN_PAUSE, rand_timing());
				reg_write(REG_BEEP_ON,      rand_timing());
				reg_write(REG_BEEP_OFF,     rand_timing());
				reg_write(REG_LED_ON_LEVEL, 16'($urandom_range(0, 127)));
				reg_write(REG_BEEP_TABLE,   16'($urandom));
			end
			gen_run(RUN_ITEMS);
			drain();
		end

		$display("covered %0d items in, %0d results checked, %0d register writes",
			items_in, results_seen, cfg_writes);
		$display("%0d settings incl. top, minimum and zero timings; %0d mismatches",
			N_PHASES + 3, fails);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mlbs_pkg.sv
sv/mlbs_regs.sv
sv/mlbs_ctrl.sv
sv/mlbs_dp.sv
sv/mode_led_pattern_beep_sequencer.sv
sv/mlbs_checker.sv
dv/testbench.sv
